// ----- hw/rtl/hfe3_pkg.sv -----
// ============================================================================
// hfe3_pkg
// Shared types and constants for the HFE v3 track stream decoder.
// ============================================================================
`default_nettype none

package hfe3_pkg;

    // Track word limit and derived widths
    localparam int MaxWords   = 4096;
    localparam int WordsWidth = $clog2(MaxWords + 1);
    localparam int IndexWidth = 12;

    // Opcodes as seen after bit reversal
    localparam logic [7:0] OpNop        = 8'hF0;
    localparam logic [7:0] OpSetIndex   = 8'hF1;
    localparam logic [7:0] OpSetBitrate = 8'hF2;
    localparam logic [7:0] OpSkipBits   = 8'hF3;
    localparam logic [7:0] OpRand       = 8'hF4;

    // Accepted bitrate operand window
    localparam logic [7:0] BitrateLow  = 8'd64;
    localparam logic [7:0] BitrateHigh = 8'd80;

    // Result status codes
    typedef enum logic [2:0] {
        ST_WORD      = 3'd0,
        ST_BITRATE   = 3'd1,
        ST_SETINDEX  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_BAD_SKIP  = 3'd4,
        ST_UNKNOWN   = 3'd5
    } t_status;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] raw_byte;
        logic       track_start;
    } t_in_item;

    // Output transaction payload
    typedef struct packed {
        t_status                 status;
        logic [31:0]             pulse_word;
        logic [IndexWidth-1:0]   word_index;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hw/rtl/hfe_v3_track_stream_decoder_unit.sv -----
// ============================================================================
// hfe_v3_track_stream_decoder_unit
// Bit-reverses raw track bytes, interprets v3 opcodes and packs the kept
// bits MSB-first into 32-bit pulse words.
// ============================================================================
//
//  Channel   Signals                              Direction  Payload
//  -------   -----------------------------------  ---------  ----------------
//  in        i_in_valid / o_in_ready / i_in_data  sink       raw_byte, track_start
//  out       o_out_valid / i_out_ready / o_out_data source   status, word, index
//  cfg       i_cfg_we / i_cfg_wdata               sink       v3_mode
//
//  One transaction per cycle sustained while the output does not stall: the
//  input register feeds the decode and bit-packing logic ahead of the result
//  register.
//  i_rst_n is synchronous, active low, and clears all track state and v3_mode.
//  A stall on the output holds the decode stage, which in turn holds the
//  input register; o_in_ready falls only when both are occupied.
// ============================================================================
`default_nettype none

module hfe_v3_track_stream_decoder_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire hfe3_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output hfe3_pkg::t_out_item     o_out_data
);

    // Configuration
    logic r_v3_mode;

    // Input register
    logic               r_in_valid;
    hfe3_pkg::t_in_item r_in;

    // Track state
    logic [31:0]                      r_shift, n_shift;
    logic [4:0]                       r_bit_count, n_bit_count;
    logic [hfe3_pkg::WordsWidth-1:0]  r_words, n_words;
    logic                             r_bitrate_pending, n_bitrate_pending;
    logic                             r_skip_pending, n_skip_pending;
    logic [2:0]                       r_skip_len, n_skip_len;
    logic                             r_halted, n_halted;

    // Result register
    logic                r_out_valid;
    hfe3_pkg::t_out_item r_out;

    // Decode stage working signals
    logic                             s_fire;
    logic [31:0]                      s_shift;
    logic [4:0]                       s_bit_count;
    logic [hfe3_pkg::WordsWidth-1:0]  s_words;
    logic                             s_bitrate_pending;
    logic                             s_skip_pending;
    logic [2:0]                       s_skip_len;
    logic                             s_halted;
    logic [7:0]                       s_byte;
    logic [7:0]                       s_bits;
    logic [3:0]                       s_nbits;
    logic                             s_data;
    logic [5:0]                       s_sum;
    logic [5:0]                       s_need;
    logic [3:0]                       s_word_shift;
    logic [3:0]                       s_keep_shift;
    logic [39:0]                      s_cat;
    logic [7:0]                       s_tail;
    logic [2:0]                       s_rem;
    logic                             s_produce;
    hfe3_pkg::t_out_item              s_result;

    // Handshakes: decode stage moves when the result slot frees up
    assign s_fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || s_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_v3_mode <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Track start clears state ahead of the byte
    always_comb begin
        if (r_in.track_start) begin
            s_shift           = '0;
            s_bit_count       = '0;
            s_words           = '0;
            s_bitrate_pending = 1'b0;
            s_skip_pending    = 1'b0;
            s_skip_len        = '0;
            s_halted          = 1'b0;
        end else begin
            s_shift           = r_shift;
            s_bit_count       = r_bit_count;
            s_words           = r_words;
            s_bitrate_pending = r_bitrate_pending;
            s_skip_pending    = r_skip_pending;
            s_skip_len        = r_skip_len;
            s_halted          = r_halted;
        end
    end

    // Stored bytes are LSB-first
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            s_byte[i] = r_in.raw_byte[7-i];
        end
    end

    // Decode: operands, opcodes and the data path selection
    always_comb begin
        n_shift           = s_shift;
        n_bit_count       = s_bit_count;
        n_words           = s_words;
        n_bitrate_pending = s_bitrate_pending;
        n_skip_pending    = s_skip_pending;
        n_skip_len        = s_skip_len;
        n_halted          = s_halted;
        s_produce         = 1'b0;
        s_result.status     = hfe3_pkg::ST_WORD;
        s_result.pulse_word = '0;
        s_result.word_index = s_words[hfe3_pkg::IndexWidth-1:0];
        s_data            = 1'b0;
        s_bits            = s_byte;
        s_nbits           = 4'd8;
        s_sum             = '0;
        s_need            = '0;
        s_word_shift      = '0;
        s_keep_shift      = '0;
        s_cat             = '0;
        s_tail            = '0;
        s_rem             = '0;

        priority if (s_halted) begin
            // ignore until track start
        end else if (s_words >= hfe3_pkg::WordsWidth'(hfe3_pkg::MaxWords)) begin
            n_halted        = 1'b1;
            s_produce       = 1'b1;
            s_result.status = hfe3_pkg::ST_TRUNCATED;
        end else if (s_bitrate_pending) begin
            n_bitrate_pending = 1'b0;
            if (s_byte < hfe3_pkg::BitrateLow || s_byte > hfe3_pkg::BitrateHigh) begin
                s_produce       = 1'b1;
                s_result.status = hfe3_pkg::ST_BITRATE;
            end
        end else if (s_skip_pending) begin
            n_skip_pending = 1'b0;
            if (s_byte == 8'd0 || s_byte >= 8'd8) begin
                n_halted        = 1'b1;
                s_produce       = 1'b1;
                s_result.status = hfe3_pkg::ST_BAD_SKIP;
            end else begin
                n_skip_len = s_byte[2:0];
            end
        end else if (s_skip_len != 3'd0) begin
            // partial byte: low s_skip_len bits only, even if it looks like an opcode
            s_data     = 1'b1;
            s_bits     = s_byte << (4'd8 - {1'b0, s_skip_len});
            s_nbits    = {1'b0, s_skip_len};
            n_skip_len = 3'd0;
        end else if (r_v3_mode && s_byte[7:4] == 4'hF) begin
            unique case (s_byte)
                hfe3_pkg::OpNop: begin
                end
                hfe3_pkg::OpSetIndex: begin
                    if (s_words != '0) begin
                        s_produce       = 1'b1;
                        s_result.status = hfe3_pkg::ST_SETINDEX;
                    end
                end
                hfe3_pkg::OpSetBitrate: begin
                    n_bitrate_pending = 1'b1;
                end
                hfe3_pkg::OpSkipBits: begin
                    n_skip_pending = 1'b1;
                end
                hfe3_pkg::OpRand: begin
                    s_data = 1'b1;
                    s_bits = 8'd0;
                end
                default: begin
                    n_halted        = 1'b1;
                    s_produce       = 1'b1;
                    s_result.status = hfe3_pkg::ST_UNKNOWN;
                end
            endcase
        end else begin
            s_data = 1'b1;
        end

        // Bit packing: at most one word completes per byte
        if (s_data) begin
            s_cat = {s_shift, s_bits};
            s_sum = {1'b0, s_bit_count} + {2'b00, s_nbits};
            if (s_sum >= 6'd32) begin
                s_need       = 6'd32 - {1'b0, s_bit_count};
                s_word_shift = 4'd8 - s_need[3:0];
                s_keep_shift = 4'd8 - s_nbits;
                s_rem        = s_sum[2:0];
                s_tail       = (s_bits >> s_keep_shift) & ~(8'hFF << s_rem);
                s_produce           = 1'b1;
                s_result.status     = hfe3_pkg::ST_WORD;
                s_result.pulse_word = 32'(s_cat >> s_word_shift);
                n_shift      = {24'd0, s_tail};
                n_bit_count  = {2'b00, s_rem};
                n_words      = s_words + 1'b1;
            end else begin
                s_keep_shift = 4'd8 - s_nbits;
                n_shift      = 32'(s_cat >> s_keep_shift);
                n_bit_count  = s_sum[4:0];
            end
        end
    end

    // Track state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift           <= '0;
            r_bit_count       <= '0;
            r_words           <= '0;
            r_bitrate_pending <= 1'b0;
            r_skip_pending    <= 1'b0;
            r_skip_len        <= '0;
            r_halted          <= 1'b0;
        end else if (s_fire) begin
            r_shift           <= n_shift;
            r_bit_count       <= n_bit_count;
            r_words           <= n_words;
            r_bitrate_pending <= n_bitrate_pending;
            r_skip_pending    <= n_skip_pending;
            r_skip_len        <= n_skip_len;
            r_halted          <= n_halted;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s_fire && s_produce) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && s_produce) begin
            r_out <= s_result;
        end
    end

    // Checks
    a_pending_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_bitrate_pending && r_skip_pending))
        else $error("bitrate and skip operands pending together");

    a_skip_len_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip_len != 3'd0) |-> (!r_bitrate_pending && !r_skip_pending))
        else $error("partial byte pending alongside an operand");

    a_words_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_words <= hfe3_pkg::WordsWidth'(hfe3_pkg::MaxWords))
        else $error("word count beyond track limit");

    a_status_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != hfe3_pkg::ST_WORD) |-> (r_out.pulse_word == 32'd0))
        else $error("non-word result carries pulse data");

endmodule

`default_nettype wire
